FILE: rtl/stg_pkg.sv
// Shared constants, types and the quarter-wave sine table for the tone generator.
`timescale 1ns / 1ps
`default_nettype none

package stg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;
    localparam int COUNT_BITS      = 24;

    localparam int AMP_W    = 15;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = SAMPLE_W + AMP_W;

    // amplitude bits consumed by each multiply cell
    localparam int DIGIT_W   = 4;
    localparam int NUM_CELLS = (AMP_W + DIGIT_W - 1) / DIGIT_W;

    localparam int QTR_BITS = TABLE_ADDR_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;

    // angle between neighbouring quarter-table entries
    localparam real QTR_STEP = 1.57079632679489661923 / QTR_SIZE;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [AMP_W-1:0] SINE_PEAK  = {AMP_W{1'b1}};
    localparam logic [AMP_W-1:0] AMP_RESET  = AMP_W'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP   = 2'd0,
        CFG_AMPLITUDE    = 2'd1,
        CFG_SAMPLE_COUNT = 2'd2
    } cfg_reg_t;

    // front stage to table lookup
    typedef struct packed {
        logic [TABLE_ADDR_BITS-1:0] addr;
        logic                       last;
        logic [AMP_W-1:0]           amp;
    } front_word_t;

    // word handed along the multiply cells
    typedef struct packed {
        logic                     last;
        logic signed [PROD_W-1:0] mcand;
        logic [AMP_W-1:0]         amp_rest;
        logic signed [PROD_W-1:0] acc;
    } cell_word_t;

    typedef logic [AMP_W-1:0] qtr_table_t [QTR_SIZE];

    // round(32767*sin(x)) over the first quarter, evaluated at elaboration
    function automatic qtr_table_t build_qtr_table();
        qtr_table_t tbl;
        real        x;
        real        y;
        for (int j = 0; j < QTR_SIZE; j++) begin
            x      = QTR_STEP * real'(j);
            y      = 32767.0 * $sin(x);
            tbl[j] = AMP_W'($rtoi(y + 0.5));
        end
        return tbl;
    endfunction

    localparam qtr_table_t QTR_TABLE = build_qtr_table();

endpackage

`default_nettype wire

FILE: rtl/sine_tone_generator_unit.sv
// Sine tone generator: DDS phase accumulator, sine table and a chain of multiply cells.
//
// Each accepted tick word on s_ yields at most one sample word on m_: sample k of a
// run is (sin_table[phase top bits] * amplitude) >>> 15, and the final sample of a run
// of sample_count words carries m_last_sample. Ticks after the run give nothing until a
// tick with s_restart set or a larger sample_count. The block takes one tick per cycle
// unless a stall on m_ fills the stages; the phase stage registers the tick at the edge
// that takes it, and its sample passes the table lookup stage and the four multiply
// cells, which fold in the amplitude four bits at a time. The phase and index adds are
// the only loops. Every stage holds its own word, so ticks keep being taken while a
// sample waits at the output as long as a stage further down is empty. The user must
// write configuration through cfg_wr_en, cfg_index and cfg_wr_data (0: phase_step,
// 1: amplitude, 2: sample_count) while the block is idle; the block does not check it.
`timescale 1ns / 1ps
`default_nettype none

module sine_tone_generator_unit import stg_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_restart,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_value,
    output logic                       m_last_sample
);

    logic [PHASE_BITS-1:0] phase_step_reg, phase_step_next;
    logic [AMP_W-1:0]      amplitude_reg, amplitude_next;
    logic [COUNT_BITS-1:0] sample_count_reg, sample_count_next;

    logic        front_valid;
    front_word_t front_word;
    logic        front_ready;

    logic       cell_valid [0:NUM_CELLS];
    cell_word_t cell_word  [0:NUM_CELLS];
    logic       cell_ready [0:NUM_CELLS];

    always_comb begin
        phase_step_next   = phase_step_reg;
        amplitude_next    = amplitude_reg;
        sample_count_next = sample_count_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PHASE_STEP:   phase_step_next   = cfg_wr_data[PHASE_BITS-1:0];
                CFG_AMPLITUDE:    amplitude_next    = cfg_wr_data[AMP_W-1:0];
                CFG_SAMPLE_COUNT: sample_count_next = cfg_wr_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= '0;
            amplitude_reg    <= AMP_RESET;
            sample_count_reg <= '0;
        end else begin
            phase_step_reg   <= phase_step_next;
            amplitude_reg    <= amplitude_next;
            sample_count_reg <= sample_count_next;
        end
    end

    stg_phase_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .phase_step   (phase_step_reg),
        .amplitude    (amplitude_reg),
        .sample_count (sample_count_reg),
        .front_valid  (front_valid),
        .front_word   (front_word),
        .front_ready  (front_ready)
    );

    stg_sine_lookup u_lookup (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .front_valid (front_valid),
        .front_word  (front_word),
        .front_ready (front_ready),
        .out_valid   (cell_valid[0]),
        .out_word    (cell_word[0]),
        .out_ready   (cell_ready[0])
    );

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        stg_mac_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_word   (cell_word[i]),
            .in_ready  (cell_ready[i]),
            .out_valid (cell_valid[i+1]),
            .out_word  (cell_word[i+1]),
            .out_ready (cell_ready[i+1])
        );
    end

    assign cell_ready[NUM_CELLS] = m_ready;

    // floor of the product over 2^15
    assign m_valid        = cell_valid[NUM_CELLS];
    assign m_sample_value = cell_word[NUM_CELLS].acc[AMP_W +: SAMPLE_W];
    assign m_last_sample  = cell_word[NUM_CELLS].last;

`ifndef SYNTHESIS
    a_front_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !front_valid |-> s_ready)
        else $error("input not ready while front stage is empty");

    a_restart_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_restart && (sample_count_reg != '0) |=> front_valid)
        else $error("restart tick with non-zero count gave no sample");

    a_single_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_restart && (sample_count_reg == COUNT_BITS'(1))
        |=> front_word.last)
        else $error("one-sample run not marked last");
`endif

endmodule

`default_nettype wire

FILE: rtl/stg_phase_front.sv
// Phase accumulator, sample counter and run control: the head of the sample chain.
`timescale 1ns / 1ps
`default_nettype none

module stg_phase_front import stg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_restart,
    input  logic [PHASE_BITS-1:0] phase_step,
    input  logic [AMP_W-1:0]      amplitude,
    input  logic [COUNT_BITS-1:0] sample_count,
    output logic                  front_valid,
    output front_word_t           front_word,
    input  logic                  front_ready
);

    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [COUNT_BITS-1:0] sample_index_reg, sample_index_next;
    logic                  valid_reg, valid_next;
    front_word_t           word_reg, word_next;

    logic                  accept;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [COUNT_BITS-1:0] index_cur;
    logic [COUNT_BITS-1:0] index_inc;
    logic                  emit;

    assign s_ready = !valid_reg || front_ready;
    assign accept  = s_valid && s_ready;

    assign phase_cur = s_restart ? '0 : phase_acc_reg;
    assign index_cur = s_restart ? '0 : sample_index_reg;
    assign index_inc = index_cur + 1'b1;
    assign emit      = index_cur < sample_count;

    always_comb begin
        phase_acc_next    = phase_acc_reg;
        sample_index_next = sample_index_reg;
        valid_next        = valid_reg;
        word_next         = word_reg;
        if (accept) begin
            phase_acc_next    = phase_cur;
            sample_index_next = index_cur;
            valid_next        = emit;
            if (emit) begin
                phase_acc_next    = phase_cur + phase_step;
                sample_index_next = index_inc;
                word_next.addr    = phase_cur[PHASE_BITS-1 -: TABLE_ADDR_BITS];
                word_next.last    = (index_inc == sample_count);
                word_next.amp     = amplitude;
            end
        end else if (front_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
            valid_reg        <= 1'b0;
        end else begin
            phase_acc_reg    <= phase_acc_next;
            sample_index_reg <= sample_index_next;
            valid_reg        <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign front_valid = valid_reg;
    assign front_word  = word_reg;

endmodule

`default_nettype wire

FILE: rtl/stg_sine_lookup.sv
// Full-wave sine lookup from the quarter table, feeding the first multiply cell.
`timescale 1ns / 1ps
`default_nettype none

module stg_sine_lookup import stg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        front_valid,
    input  front_word_t front_word,
    output logic        front_ready,
    output logic        out_valid,
    output cell_word_t  out_word,
    input  logic        out_ready
);

    logic       valid_reg, valid_next;
    cell_word_t word_reg, word_next;

    logic [1:0]                quad;
    logic [QTR_BITS-1:0]       off;
    logic [QTR_BITS-1:0]       off_mirror;
    logic [AMP_W-1:0]          mag;
    logic signed [SAMPLE_W-1:0] sine_val;

    assign front_ready = !valid_reg || out_ready;

    assign quad       = front_word.addr[TABLE_ADDR_BITS-1 -: 2];
    assign off        = front_word.addr[QTR_BITS-1:0];
    assign off_mirror = ~off + 1'b1;

    always_comb begin
        if (!quad[0]) begin
            mag = QTR_TABLE[off];
        end else if (off == '0) begin
            mag = SINE_PEAK;     // peak of the wave, negated in the lower half
        end else begin
            mag = QTR_TABLE[off_mirror];
        end
        sine_val = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (front_ready) begin
            valid_next = front_valid;
            if (front_valid) begin
                word_next.last     = front_word.last;
                word_next.mcand    = {{(PROD_W-SAMPLE_W){sine_val[SAMPLE_W-1]}}, sine_val};
                word_next.amp_rest = front_word.amp;
                word_next.acc      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

FILE: rtl/stg_mac_cell.sv
// One multiply cell: adds sine times a few amplitude bits and passes the word on.
`timescale 1ns / 1ps
`default_nettype none

module stg_mac_cell import stg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  cell_word_t in_word,
    output logic       in_ready,
    output logic       out_valid,
    output cell_word_t out_word,
    input  logic       out_ready
);

    logic       valid_reg, valid_next;
    cell_word_t word_reg, word_next;

    logic [DIGIT_W-1:0]               digit;
    logic signed [PROD_W+DIGIT_W:0]   partial;

    assign in_ready = !valid_reg || out_ready;

    assign digit   = in_word.amp_rest[DIGIT_W-1:0];
    assign partial = in_word.mcand * $signed({1'b0, digit});

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                word_next.last     = in_word.last;
                word_next.mcand    = in_word.mcand <<< DIGIT_W;
                word_next.amp_rest = in_word.amp_rest >> DIGIT_W;
                word_next.acc      = in_word.acc + partial[PROD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

FILE: dv/stg_sample_checker.sv
// Sample checker for the tone generator: predicts each sample word and compares it on m_.
`timescale 1ns / 1ps

module stg_sample_checker import stg_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_restart,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [SAMPLE_W-1:0] m_sample_value,
    input  logic                       m_last_sample,
    output int                         mismatches,
    output int                         samples_owed
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } sample_word_t;

    localparam int LUT_SIZE = 1 << TABLE_ADDR_BITS;

    int                         quarter_wave [QTR_SIZE+1];
    logic signed [SAMPLE_W-1:0] sine_lut [LUT_SIZE];

    logic [PHASE_BITS-1:0] step_reg;
    logic [AMP_W-1:0]      amp_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [PHASE_BITS-1:0] phase;
    logic [COUNT_BITS-1:0] sample_idx;
    sample_word_t          owed_q [$];
    int                    err_cnt = 0;

    // full-wave table folded out of one quarter; the quarter's end point is exact full scale
    initial begin
        int quad;
        int off;
        int v;
        for (int j = 0; j < QTR_SIZE; j++)
            quarter_wave[j] = $rtoi(32767.0 * $sin(3.14159265358979323846 * j
                                                   / (2.0 * QTR_SIZE)) + 0.5);
        quarter_wave[QTR_SIZE] = 32767;
        for (int k = 0; k < LUT_SIZE; k++) begin
            quad = (k >> QTR_BITS) & 3;
            off  = k & (QTR_SIZE - 1);
            v    = (quad & 1) ? quarter_wave[QTR_SIZE - off] : quarter_wave[off];
            sine_lut[k] = SAMPLE_W'((quad & 2) ? -v : v);
        end
    end

    // advances the oscillator by one tick; returns 0 when the run is over
    function automatic bit next_sample(input logic restart, output sample_word_t w);
        int prod;
        w = '0;
        if (restart) begin
            phase      = '0;
            sample_idx = '0;
        end
        if (sample_idx >= count_reg)
            return 1'b0;
        prod    = int'(sine_lut[phase[PHASE_BITS-1 -: TABLE_ADDR_BITS]]) * int'(amp_reg);
        w.value = SAMPLE_W'(prod >>> 15);
        w.last  = (32'(sample_idx) + 1 == 32'(count_reg));
        phase      = phase + step_reg;
        sample_idx = sample_idx + 1'b1;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        sample_word_t want;
        sample_word_t got;
        if (!aresetn) begin
            step_reg   = '0;
            amp_reg    = AMP_RESET;
            count_reg  = '0;
            phase      = '0;
            sample_idx = '0;
            owed_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PHASE_STEP:   step_reg  = cfg_wr_data[PHASE_BITS-1:0];
                    CFG_AMPLITUDE:    amp_reg   = cfg_wr_data[AMP_W-1:0];
                    CFG_SAMPLE_COUNT: count_reg = cfg_wr_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready && next_sample(s_restart, want))
                owed_q = {owed_q, want};
            if (m_valid && m_ready) begin
                got.value = m_sample_value;
                got.last  = m_last_sample;
                if (owed_q.size() == 0) begin
                    $error("sample word with none owed: sample_value %0d last_sample %0b",
                           got.value, got.last);
                    err_cnt++;
                end else begin
                    want = owed_q.pop_front();
                    if (got.value !== want.value) begin
                        $error("sample_value: expected %0d, got %0d", want.value, got.value);
                        err_cnt++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_sample: expected %0b, got %0b", want.last, got.last);
                        err_cnt++;
                    end
                end
            end
        end
        mismatches   <= err_cnt;
        samples_owed <= owed_q.size();
    end

endmodule

FILE: dv/sine_tone_generator_unit_test.sv
// Testbench top for the tone generator: reset, register writes, tick stimulus and verdict.
`timescale 1ns / 1ps

module sine_tone_generator_unit_test;
    import stg_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_TICKS  = 1700;
    localparam int CALM_TAIL     = 300;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = CFG_PHASE_STEP;
    logic [CFG_DATA_W-1:0]      cfg_wr_data = '0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic                       s_restart   = 1'b0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_value;
    logic                       m_last_sample;

    int mismatches;
    int samples_owed;
    bit idle_on    = 1'b0;
    int ready_hold = 0;
    int quiet      = 0;
    // stimulus-side run position, only to steer restarts
    int run_len    = 0;
    int run_idx    = 0;
    int ticks_sent = 0;

    always #1 aclk = ~aclk;

    sine_tone_generator_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value),
        .m_last_sample  (m_last_sample)
    );

    stg_sample_checker sample_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value),
        .m_last_sample  (m_last_sample),
        .mismatches     (mismatches),
        .samples_owed   (samples_owed)
    );

    // receiver back-pressure in bursts
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= (ready_hold == 1);
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(1, 15);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_SAMPLE_COUNT)
            run_len = int'(data[COUNT_BITS-1:0]);
    endtask

    task automatic send_tick(input logic rs);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        if (rs)
            run_idx = 0;
        if (run_idx < run_len)
            run_idx++;
    endtask

    // hold the sender until every owed word is out, then let the pipe empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (samples_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            2:       v = $urandom_range(1, 65536);
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 3) != 0)
            cfg_write(CFG_PHASE_STEP, v);
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 32'd32767;
            2:       v = $urandom;
            default: v = $urandom_range(0, 32767);
        endcase
        if ($urandom_range(0, 3) != 0)
            cfg_write(CFG_AMPLITUDE, v);
        case ($urandom_range(0, 11))
            0:       v = '0;
            1:       v = '1;
            2:       v = $urandom;
            default: v = $urandom_range(1, 48);
        endcase
        if ($urandom_range(0, 2) != 0)
            cfg_write(CFG_SAMPLE_COUNT, v);
        if ($urandom_range(0, 15) == 0)
            cfg_write(CFG_SPARE_IDX, $urandom);
    endtask

    initial begin
        logic rs;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        // zero run length after reset: ticks give nothing
        send_tick(1'b0);
        send_tick(1'b1);
        settle();

        // reset amplitude, quarter-turn steps, then a tick past the end of the run
        cfg_write(CFG_PHASE_STEP, 32'h4000_0000);
        cfg_write(CFG_SAMPLE_COUNT, 32'd3);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        settle();

        // full scale; data wider than the register
        cfg_write(CFG_AMPLITUDE, 32'hFFFF_FFFF);
        cfg_write(CFG_SAMPLE_COUNT, 32'd5);
        cfg_write(CFG_SPARE_IDX, 32'hFFFF_FFFF);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        settle();

        // silent output, phase wrapping every tick
        cfg_write(CFG_AMPLITUDE, 32'd0);
        cfg_write(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        cfg_write(CFG_SAMPLE_COUNT, 32'hFF00_0002);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        settle();

        // longest run, then the run length moved under and over the index
        cfg_write(CFG_SAMPLE_COUNT, 32'h00FF_FFFF);
        cfg_write(CFG_AMPLITUDE, 32'd1);
        cfg_write(CFG_PHASE_STEP, 32'h0123_4567);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        settle();
        cfg_write(CFG_SAMPLE_COUNT, 32'd2);
        send_tick(1'b0);
        settle();
        cfg_write(CFG_SAMPLE_COUNT, 32'd6);
        cfg_write(CFG_AMPLITUDE, 32'd32767);
        repeat (3) send_tick(1'b0);
        settle();

        // restart while a run is going
        cfg_write(CFG_SAMPLE_COUNT, 32'd100);
        send_tick(1'b0);
        send_tick(1'b1);

        ticks_sent = 0;
        while (ticks_sent < RANDOM_TICKS) begin
            idle_on = (ticks_sent < RANDOM_TICKS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            settle();
            random_config();
            repeat ($urandom_range(30, 120)) begin
                // mostly whole runs; stray ticks after the end and early restarts now and then
                if (run_idx >= run_len)
                    rs = ($urandom_range(0, 3) != 0);
                else
                    rs = ($urandom_range(0, 40) == 0);
                send_tick(rs);
                if ($urandom_range(0, 149) == 0)
                    settle();
            end
        end

        settle();
        @(negedge aclk);
        if (mismatches == 0 && samples_owed == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/stg_pkg.sv
rtl/stg_phase_front.sv
rtl/stg_sine_lookup.sv
rtl/stg_mac_cell.sv
rtl/sine_tone_generator_unit.sv
dv/stg_sample_checker.sv
dv/sine_tone_generator_unit_test.sv
